// File: design/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 4;

  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_TAB,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } cmd_t;

endpackage

// File: design/text_console_writer.sv
// Channel   Direction  Handshake               Word
// in        in         in_valid_i/in_stall_o   req_type_i, char_code_i, cell_index_i
// out       out        out_valid_o/out_stall_i cursor_pos_o, cursor_refreshed_o,
//                                              scrolled_o, cell_data_o
// cfg       in         cfg_valid_i/cfg_ready_o text_attribute_i
//
// A two-word queue decouples intake from the cell sequencer; one result per word.
// Put, newline, backspace, tab finish in ST_IDLE unless they scroll; read passes ST_READ
// (registered RAM read). Scroll copies the rows up in ST_SCROLL and blanks the last row
// in ST_FILL; clear blanks all cells in ST_FILL; one cell per cycle through the single
// write port of the cell RAM. After reset a clearing pass zeroes the cells; in_stall_o
// stays high meanwhile. cfg_ready_o is always high.
module text_console_writer #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcw_pkg::REQ_W-1:0]    req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]    cell_index_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]   text_attribute_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcw_pkg::POS_W-1:0]    cursor_pos_o,
  output logic                         cursor_refreshed_o,
  output logic                         scrolled_o,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data_o
);

  tcw_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop, back_ready;

  assign cfg_ready_o = 1'b1;

  tcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .back_ready_i (back_ready),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  tcw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i && cfg_ready_o),
    .text_attribute_i   (text_attribute_i),
    .ready_o            (back_ready),
    .cmd_valid_i        (cmd_valid),
    .cmd_i              (cmd),
    .cmd_pop_o          (cmd_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .cursor_pos_o       (cursor_pos_o),
    .cursor_refreshed_o (cursor_refreshed_o),
    .scrolled_o         (scrolled_o),
    .cell_data_o        (cell_data_o)
  );

endmodule

// File: design/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tcw_front.sv
module tcw_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcw_pkg::REQ_W-1:0]    req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]    cell_index_i,
  input  logic                         back_ready_i,
  output logic                         cmd_valid_o,
  output tcw_pkg::cmd_t                cmd_o,
  input  logic                         cmd_pop_i
);

  tcw_pkg::cmd_t entry_q [2];
  tcw_pkg::cmd_t new_cmd;
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q, count_d;
  logic          push;

  always_comb begin
    new_cmd.char_code  = char_code_i;
    new_cmd.cell_index = cell_index_i;
    new_cmd.op         = tcw_pkg::OP_NOP;
    priority if (req_type_i == tcw_pkg::REQ_PUT) begin
      priority if (char_code_i == tcw_pkg::CH_NEWLINE) begin
        new_cmd.op = tcw_pkg::OP_NEWLINE;
      end else if (char_code_i == tcw_pkg::CH_BACKSPACE) begin
        new_cmd.op = tcw_pkg::OP_BACKSPACE;
      end else if (char_code_i == tcw_pkg::CH_TAB) begin
        new_cmd.op = tcw_pkg::OP_TAB;
      end else begin
        new_cmd.op = tcw_pkg::OP_PUT;
      end
    end else if (req_type_i == tcw_pkg::REQ_CLEAR) begin
      new_cmd.op = tcw_pkg::OP_CLEAR;
    end else if (req_type_i == tcw_pkg::REQ_READ) begin
      new_cmd.op = tcw_pkg::OP_READ;
    end else begin
      new_cmd.op = tcw_pkg::OP_NOP;
    end
  end

  assign in_stall_o  = (count_q == 2'd2) || !back_ready_i;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !cmd_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step");

endmodule

// File: design/tcw_back.sv
module tcw_back #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [tcw_pkg::ATTR_W-1:0]   text_attribute_i,
  output logic                         ready_o,
  input  logic                         cmd_valid_i,
  input  tcw_pkg::cmd_t                cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcw_pkg::POS_W-1:0]    cursor_pos_o,
  output logic                         cursor_refreshed_o,
  output logic                         scrolled_o,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data_o
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int AW      = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int PH_W    = $clog2(TAB_STEP);
  localparam int XW      = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;
  localparam int PH_LAST = (COLUMNS - 1) % TAB_STEP;

  tcw_pkg::state_e state_q, state_d;

  logic [AW-1:0]              cnt_q, cnt_d;
  logic [COL_W-1:0]           col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic [PH_W-1:0]            phase_q, phase_d;
  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  logic                       out_valid_q, out_valid_d;
  logic                       refr_q, refr_d;
  logic                       scr_q, scr_d;
  logic [tcw_pkg::CELL_W-1:0] data_q, data_d;
  logic                       rng_q, rng_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic                       out_free, take;
  logic [AW-1:0]              cur_addr;
  logic [XW-1:0]              pos_x, idx_x;
  logic [COL_W:0]             col_inc, tab_col;
  logic [ROW_W:0]             row_inc;
  logic                       wrap, tab_wrap, need_scroll, in_range;
  logic [COL_W-1:0]           bs_col;
  logic [PH_W-1:0]            phase_inc, phase_dec;
  logic [tcw_pkg::CELL_W-1:0] blank;
  logic                       adv, emit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = (state_q == tcw_pkg::ST_IDLE) && cmd_valid_i && out_free;
  assign cmd_pop_o = take;
  assign ready_o  = (state_q != tcw_pkg::ST_INIT);

  assign cur_addr    = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign pos_x       = XW'(cur_addr);
  assign idx_x       = XW'(cmd_i.cell_index);
  assign in_range    = idx_x < XW'(CELLS);
  assign col_inc     = {1'b0, col_q} + (COL_W+1)'(1);
  assign wrap        = col_inc == (COL_W+1)'(COLUMNS);
  assign row_inc     = {1'b0, row_q} + (ROW_W+1)'(1);
  assign need_scroll = row_inc == (ROW_W+1)'(ROWS);
  assign tab_col     = {1'b0, col_q} + (COL_W+1)'(TAB_STEP) - (COL_W+1)'(phase_q);
  assign tab_wrap    = tab_col >= (COL_W+1)'(COLUMNS);
  assign bs_col      = (col_q == '0) ? '0 : col_q - COL_W'(1);
  assign phase_inc   = (phase_q == PH_W'(TAB_STEP - 1)) ? '0 : phase_q + PH_W'(1);
  assign phase_dec   = (phase_q == '0) ? PH_W'(TAB_STEP - 1) : phase_q - PH_W'(1);
  assign blank       = {attr_q, tcw_pkg::CH_SPACE};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::ST_INIT: begin
        if (cnt_q == AW'(CELLS - 1)) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (take) begin
          unique case (cmd_i.op)
            tcw_pkg::OP_PUT: begin
              if (wrap && need_scroll) state_d = tcw_pkg::ST_SCROLL;
            end
            tcw_pkg::OP_NEWLINE: begin
              if (need_scroll) state_d = tcw_pkg::ST_SCROLL;
            end
            tcw_pkg::OP_TAB: begin
              if (tab_wrap && need_scroll) state_d = tcw_pkg::ST_SCROLL;
            end
            tcw_pkg::OP_CLEAR:     state_d = tcw_pkg::ST_FILL;
            tcw_pkg::OP_READ:      state_d = tcw_pkg::ST_READ;
            tcw_pkg::OP_BACKSPACE: state_d = tcw_pkg::ST_IDLE;
            tcw_pkg::OP_NOP:       state_d = tcw_pkg::ST_IDLE;
            default:               state_d = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_READ: state_d = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_SCROLL: begin
        if (cnt_q == AW'(CELLS - COLUMNS)) begin
          state_d = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_FILL: begin
        if (cnt_q == AW'(CELLS - 1)) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    refr_d      = refr_q;
    scr_d       = scr_q;
    data_d      = data_q;
    rng_d       = rng_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_addr;
    ram_wdata   = blank;
    ram_raddr   = cnt_q + AW'(COLUMNS);
    adv         = 1'b0;
    emit        = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
        cnt_d     = cnt_q + AW'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (take) begin
          refr_d = 1'b0;
          scr_d  = 1'b0;
          data_d = '0;
          unique case (cmd_i.op)
            tcw_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_wdata = {attr_q, cmd_i.char_code};
              refr_d    = 1'b1;
              emit      = 1'b1;
              if (wrap) begin
                col_d   = '0;
                phase_d = '0;
                adv     = 1'b1;
              end else begin
                col_d   = col_inc[COL_W-1:0];
                phase_d = phase_inc;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              col_d   = '0;
              phase_d = '0;
              refr_d  = 1'b1;
              adv     = 1'b1;
              emit    = 1'b1;
            end
            tcw_pkg::OP_BACKSPACE: begin
              ram_we    = 1'b1;
              ram_waddr = cur_addr - AW'(col_q != '0);
              refr_d    = 1'b1;
              emit      = 1'b1;
              if (bs_col == '0 && row_q != '0) begin
                row_d   = row_q - ROW_W'(1);
                col_d   = COL_W'(COLUMNS - 1);
                phase_d = PH_W'(PH_LAST);
              end else begin
                col_d   = bs_col;
                phase_d = (col_q == '0) ? '0 : phase_dec;
              end
            end
            tcw_pkg::OP_TAB: begin
              emit = 1'b1;
              phase_d = '0;
              if (tab_wrap) begin
                col_d  = '0;
                refr_d = 1'b1;
                adv    = 1'b1;
              end else begin
                col_d = tab_col[COL_W-1:0];
              end
            end
            tcw_pkg::OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              phase_d = '0;
              refr_d  = 1'b1;
              cnt_d   = '0;
            end
            tcw_pkg::OP_READ: begin
              ram_raddr = idx_x[AW-1:0];
              rng_d     = in_range;
            end
            tcw_pkg::OP_NOP: begin
              emit = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
          if (adv) begin
            if (need_scroll) begin
              scr_d = 1'b1;
              cnt_d = '0;
              emit  = 1'b0;
            end else begin
              row_d = row_inc[ROW_W-1:0];
            end
          end
          if (emit) begin
            out_valid_d = 1'b1;
          end
        end
      end
      tcw_pkg::ST_READ: begin
        data_d      = rng_q ? ram_rdata : '0;
        out_valid_d = 1'b1;
      end
      tcw_pkg::ST_SCROLL: begin
        // read row below, write it in the next cycle
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - AW'(1);
        ram_wdata = ram_rdata;
        if (cnt_q != AW'(CELLS - COLUMNS)) begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      tcw_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      phase_q     <= '0;
      attr_q      <= tcw_pkg::ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        attr_q <= text_attribute_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    refr_q <= refr_d;
    scr_q  <= scr_d;
    data_q <= data_d;
    rng_q  <= rng_d;
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign cursor_pos_o       = pos_x[tcw_pkg::POS_W-1:0];
  assign cursor_refreshed_o = refr_q;
  assign scrolled_o         = scr_q;
  assign cell_data_o        = data_q;

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < (COL_W+1)'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_q} < (ROW_W+1)'(ROWS))
    else $error("cursor row out of range");

  a_word_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == tcw_pkg::ST_IDLE)
    else $error("result pending while sequencer busy");

  a_scroll_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_SCROLL |-> scr_q && row_q == ROW_W'(ROWS - 1))
    else $error("scroll pass without scroll flag");

endmodule

// File: tb/text_console_writer_tb.sv
module text_console_writer_tb;

  localparam int COLS      = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS      = tcw_pkg::ROWS_DEF;
  localparam int TAB       = tcw_pkg::TAB_STEP_DEF;
  localparam int CELLS     = COLS * ROWS;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 50;
  localparam logic [tcw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::REQ_W-1:0]  req;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::IDX_W-1:0]  idx;
  } console_word_t;

  typedef struct packed {
    logic [tcw_pkg::POS_W-1:0]  pos;
    logic                       refreshed;
    logic                       scrolled;
    logic [tcw_pkg::CELL_W-1:0] data;
  } console_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall_o;
  logic [tcw_pkg::REQ_W-1:0]  req_type = '0;
  logic [tcw_pkg::CHAR_W-1:0] char_code = '0;
  logic [tcw_pkg::IDX_W-1:0]  cell_index = '0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready_o;
  logic [tcw_pkg::ATTR_W-1:0] text_attr = '0;
  logic                       out_valid_o;
  logic                       out_stall = 1'b0;
  logic [tcw_pkg::POS_W-1:0]  cursor_pos_o;
  logic                       cursor_refreshed_o;
  logic                       scrolled_o;
  logic [tcw_pkg::CELL_W-1:0] cell_data_o;

  text_console_writer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type),
    .char_code_i       (char_code),
    .cell_index_i      (cell_index),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .text_attribute_i  (text_attr),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .cursor_pos_o      (cursor_pos_o),
    .cursor_refreshed_o(cursor_refreshed_o),
    .scrolled_o        (scrolled_o),
    .cell_data_o       (cell_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the console
  logic [tcw_pkg::CELL_W-1:0] screen_model [CELLS];
  logic [tcw_pkg::ATTR_W-1:0] attr_model = tcw_pkg::ATTR_RESET;
  int cur_col = 0;
  int cur_row = 0;

  console_word_t   console_words_q[$];
  console_result_t console_results_q[$];
  console_word_t   cur_word = '0;

  int  send_gap = 0;
  int  stall_len = 0;
  bit  steady_phase = 1'b0;
  int  fail_cnt = 0;
  int  words_sent = 0;
  int  results_checked = 0;
  int  scroll_cnt = 0;
  int  clear_cnt = 0;
  int  read_cnt = 0;
  int  attr_writes = 0;
  int  idle_cycles = 0;

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
  end

  function automatic logic [tcw_pkg::CELL_W-1:0] blank_cell();
    return {attr_model, tcw_pkg::CH_SPACE};
  endfunction

  function automatic logic scroll_if_past_bottom();
    if (cur_row < ROWS) return 1'b0;
    for (int i = 0; i + COLS < CELLS; i++) screen_model[i] = screen_model[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = blank_cell();
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic console_result_t console_apply(console_word_t w);
    console_result_t r;
    r = '0;
    unique case (w.req)
      tcw_pkg::REQ_PUT: begin
        if (w.ch == tcw_pkg::CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
          r.scrolled = scroll_if_past_bottom();
          r.refreshed = 1'b1;
        end else if (w.ch == tcw_pkg::CH_BACKSPACE) begin
          if (cur_col > 0) cur_col--;
          screen_model[cur_row * COLS + cur_col] = blank_cell();
          if (cur_col == 0 && cur_row > 0) begin
            cur_row--;
            cur_col = COLS - 1;
          end
          r.refreshed = 1'b1;
        end else if (w.ch == tcw_pkg::CH_TAB) begin
          cur_col = (cur_col / TAB + 1) * TAB;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
            r.scrolled = scroll_if_past_bottom();
            r.refreshed = 1'b1;
          end
        end else begin
          screen_model[cur_row * COLS + cur_col] = {attr_model, w.ch};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
          r.scrolled = scroll_if_past_bottom();
          r.refreshed = 1'b1;
        end
      end
      tcw_pkg::REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
        r.refreshed = 1'b1;
      end
      tcw_pkg::REQ_READ: begin
        if (w.idx < CELLS) r.data = screen_model[w.idx];
      end
      default: ;
    endcase
    r.pos = tcw_pkg::POS_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  // mostly short gaps, a few long ones; none in the steady phase
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_phase) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_words
    console_word_t w;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        console_results_q.push_back(console_apply(cur_word));
        words_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (console_words_q.size() > 0) begin
          w = console_words_q.pop_front();
          cur_word   <= w;
          req_type   <= w.req;
          char_code  <= w.ch;
          cell_index <= w.idx;
          in_valid   <= 1'b1;
          send_gap   <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_results
    console_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (console_results_q.size() == 0) begin
          $error("result with nothing expected: pos %0d", cursor_pos_o);
          fail_cnt++;
        end else begin
          want = console_results_q.pop_front();
          results_checked++;
          if (want.scrolled) scroll_cnt++;
          if (cursor_pos_o !== want.pos) begin
            $error("cursor_pos: expected %0d, got %0d", want.pos, cursor_pos_o);
            fail_cnt++;
          end
          if (cursor_refreshed_o !== want.refreshed) begin
            $error("cursor_refreshed: expected %0d, got %0d", want.refreshed,
                   cursor_refreshed_o);
            fail_cnt++;
          end
          if (scrolled_o !== want.scrolled) begin
            $error("scrolled: expected %0d, got %0d", want.scrolled, scrolled_o);
            fail_cnt++;
          end
          if (cell_data_o !== want.data) begin
            $error("cell_data: expected 0x%04h, got 0x%04h", want.data, cell_data_o);
            fail_cnt++;
          end
        end
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        stall_len <= stall_len - 1;
      end else if (!steady_phase && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        stall_len <= pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog: no handshake for %0d cycles", WDOG_MAX);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_word(input logic [tcw_pkg::REQ_W-1:0] req,
                          input logic [tcw_pkg::CHAR_W-1:0] ch,
                          input logic [tcw_pkg::IDX_W-1:0] idx);
    console_word_t w;
    w.req = req;
    w.ch  = ch;
    w.idx = idx;
    console_words_q.push_back(w);
    if (req == tcw_pkg::REQ_CLEAR) clear_cnt++;
    if (req == tcw_pkg::REQ_READ) read_cnt++;
  endtask

  function automatic logic [tcw_pkg::CHAR_W-1:0] text_byte();
    if ($urandom_range(0, 99) < 20) return tcw_pkg::CHAR_W'($urandom_range(0, 255));
    return tcw_pkg::CHAR_W'($urandom_range(8'h20, 8'h7e));
  endfunction

  function automatic logic [tcw_pkg::IDX_W-1:0] any_idx();
    return tcw_pkg::IDX_W'($urandom_range(0, 2047));
  endfunction

  // text lines, newline runs, control bursts, reads, rare clears and unused codes
  task automatic gen_traffic(input int n);
    int cnt;
    int kind;
    int len;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(1, 90);
        for (int i = 0; i < len && cnt < n; i++, cnt++)
          add_word(tcw_pkg::REQ_PUT, text_byte(), any_idx());
        if (cnt < n && $urandom_range(0, 1)) begin
          add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, any_idx());
          cnt++;
        end
      end else if (kind < 60) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
        for (int i = 0; i < len && cnt < n; i++, cnt++)
          add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, any_idx());
      end else if (kind < 75) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len && cnt < n; i++, cnt++)
          add_word(tcw_pkg::REQ_PUT,
                   $urandom_range(0, 1) ? tcw_pkg::CH_TAB : tcw_pkg::CH_BACKSPACE,
                   any_idx());
      end else if (kind < 92) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len && cnt < n; i++, cnt++)
          add_word(tcw_pkg::REQ_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                   ($urandom_range(0, 9) == 0)
                     ? tcw_pkg::IDX_W'($urandom_range(CELLS, 2047))
                     : tcw_pkg::IDX_W'($urandom_range(0, CELLS - 1)));
      end else if (kind < 96) begin
        add_word(tcw_pkg::REQ_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)), any_idx());
        cnt++;
      end else begin
        add_word(REQ_UNUSED, tcw_pkg::CHAR_W'($urandom_range(0, 255)), any_idx());
        cnt++;
      end
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (console_words_q.size() > 0 || in_valid || console_results_q.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] v);
    text_attr <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    attr_model = v;
    attr_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [tcw_pkg::ATTR_W-1:0] attrs [5];
    attrs[0] = 8'hff;
    attrs[1] = 8'h00;
    attrs[2] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
    attrs[3] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
    attrs[4] = tcw_pkg::ATTR_RESET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cells still zero from reset, reads past the end, cursor edge moves
    add_word(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    add_word(tcw_pkg::REQ_READ, 8'hff, 11'h7ff);
    add_word(tcw_pkg::REQ_READ, 8'h00, 11'd1999);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    add_word(tcw_pkg::REQ_PUT, 8'h41, 11'h7ff);
    add_word(tcw_pkg::REQ_PUT, 8'h00, 11'd0);
    add_word(tcw_pkg::REQ_PUT, 8'hff, 11'd0);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_TAB, 11'd0);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_TAB, 11'd0);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_TAB, 11'd0);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    add_word(tcw_pkg::REQ_PUT, 8'h7e, 11'd0);
    add_word(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    add_word(tcw_pkg::REQ_READ, 8'h00, 11'd79);
    add_word(tcw_pkg::REQ_READ, 8'h00, 11'd80);
    add_word(REQ_UNUSED, 8'hff, 11'h7ff);
    add_word(tcw_pkg::REQ_CLEAR, 8'h00, 11'd0);
    add_word(tcw_pkg::REQ_READ, 8'h00, 11'd5);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    add_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_attribute(attrs[p]);
      steady_phase <= (p == 2);
      gen_traffic(190);
      wait_drained();
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (console_results_q.size() != 0) begin
      $error("%0d results never arrived", console_results_q.size());
      fail_cnt++;
    end
    $display("%0d words in, %0d results checked: %0d scrolls, %0d clears, %0d reads",
             words_sent, results_checked, scroll_cnt, clear_cnt, read_cnt);
    $display("%0d attribute settings used, incl. 0x00 and 0xff", attr_writes);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_writer.sv
tb/text_console_writer_tb.sv
